// ===== hw/rtl/osac_pkg.sv =====
// ----------------------------------------------------------------------------
// osac_pkg
// Shared types, codes and helpers of the online sparse autoencoder classifier.
// ----------------------------------------------------------------------------
package osac_pkg;

    // Widths fixed by the item and weight formats
    localparam int ACT_W  = 16;
    localparam int WGT_W  = 24;
    localparam int QUOT_W = 23;

    // Saturated quotient and divider iteration count
    localparam logic [QUOT_W-1:0] QUOT_MAX  = {QUOT_W{1'b1}};
    localparam logic [4:0]        DIV_STEPS = 5'd23;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_LEARN_RATE      = 2'd0;
    localparam logic [1:0] CFG_SPARSITY_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_SPARSITY_TARGET = 2'd2;

    // Register reset values
    localparam logic [ACT_W-1:0] RST_LEARN_RATE      = 16'd66;
    localparam logic [ACT_W-1:0] RST_SPARSITY_WEIGHT = 16'd6554;
    localparam logic [ACT_W-1:0] RST_SPARSITY_TARGET = 16'd3277;

    // Sequencer states: forward, classify, output layer, backward per hidden
    // unit, output weight update, result hand-off
    typedef enum logic [34:0] {
        S_IDLE = 35'b1 << 0,
        S_F0   = 35'b1 << 1,
        S_F1   = 35'b1 << 2,
        S_F2   = 35'b1 << 3,
        S_F3   = 35'b1 << 4,
        S_C0   = 35'b1 << 5,
        S_C1   = 35'b1 << 6,
        S_T0   = 35'b1 << 7,
        S_T1   = 35'b1 << 8,
        S_T2   = 35'b1 << 9,
        S_T3   = 35'b1 << 10,
        S_B0   = 35'b1 << 11,
        S_B0W  = 35'b1 << 12,
        S_B1   = 35'b1 << 13,
        S_B1W  = 35'b1 << 14,
        S_B2   = 35'b1 << 15,
        S_B3   = 35'b1 << 16,
        S_B4   = 35'b1 << 17,
        S_B5   = 35'b1 << 18,
        S_B6   = 35'b1 << 19,
        S_B7   = 35'b1 << 20,
        S_B8   = 35'b1 << 21,
        S_B9   = 35'b1 << 22,
        S_B10  = 35'b1 << 23,
        S_B11  = 35'b1 << 24,
        S_B12  = 35'b1 << 25,
        S_U0   = 35'b1 << 26,
        S_U1   = 35'b1 << 27,
        S_U2   = 35'b1 << 28,
        S_U3   = 35'b1 << 29,
        S_U4   = 35'b1 << 30,
        S_U5   = 35'b1 << 31,
        S_U6   = 35'b1 << 32,
        S_U7   = 35'b1 << 33,
        S_OUT  = 35'b1 << 34
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [ACT_W:0]    num;
        logic [ACT_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // Weight minus step, saturated to the signed weight range
    function automatic logic signed [WGT_W-1:0] sat_sub(
        input logic signed [WGT_W-1:0] w,
        input logic signed [53:0]       dec
    );
        logic signed [55:0] v;
        v = 56'(w) - 56'(dec);
        if (v > 56'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -56'sd8388608) begin
            return 24'sh800000;
        end
        return v[WGT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/osac_div.sv =====
// ----------------------------------------------------------------------------
// osac_div
// Saturating restoring divider: (num << 16) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module osac_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  osac_pkg::t_div_req  i_req,
    output osac_pkg::t_div_rsp  o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt,  n_cnt;
    logic [15:0] r_rem,  n_rem;
    logic [15:0] r_den,  n_den;
    logic [22:0] r_sh,   n_sh;
    logic [22:0] r_q,    n_q;

    logic [16:0] w_trial;
    logic [16:0] w_diff;
    logic        w_ge;

    // One restoring step
    assign w_trial = {r_rem, r_sh[22]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_sh   = r_sh;
        n_q    = r_q;
        if (i_req.start) begin
            // quotient of 2^23 or more saturates at once
            if ({7'd0, i_req.num} >= {1'b0, i_req.den, 7'd0}) begin
                n_q    = osac_pkg::QUOT_MAX;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem  = {6'd0, i_req.num[16:7]};
                n_sh   = {i_req.num[6:0], 16'd0};
                n_den  = i_req.den;
                n_q    = '0;
                n_cnt  = osac_pkg::DIV_STEPS;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[15:0] : w_trial[15:0];
            n_q   = {r_q[21:0], w_ge};
            n_sh  = {r_sh[21:0], 1'b0};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_sh  <= n_sh;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== hw/rtl/online_sparse_autoencoder_classifier_core.sv =====
// ----------------------------------------------------------------------------
// online_sparse_autoencoder_classifier_core
// 1-2-1 sigmoid autoencoder that trains or classifies one sensor sample a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries i_cmd (0 train, 1 classify)
//   and i_sample. Output channel o_out_valid / i_out_stall carries one result
//   beat per input beat. Registers are to be written on i_cfg_we only while
//   idle; the core itself does not enforce this. One shared 36x18 multiplier
//   and one bit-serial divider run under a sequencer; o_in_stall is high from
//   acceptance until the result is loaded. In a train beat each of the four
//   KL quotients runs in the divider (23 quotient bits plus issue and
//   capture) unless it saturates; the rest is one multiplier step per cycle.
//   The next beat is accepted the cycle after the result is loaded; the
//   result register holds it while the receiver stalls, and a finished item
//   waits in its last step if the previous result has not been taken.
//   Reset (synchronous, active low) restores weights and registers to their
//   constants and empties the output register.
// ----------------------------------------------------------------------------
module online_sparse_autoencoder_classifier_core #(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int SIGMOID_ENTRIES  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_white,
    output logic [15:0] o_hidden_act_first,
    output logic [15:0] o_hidden_act_second,
    output logic [15:0] o_reconstruction
);

    localparam int IW   = $clog2(SIGMOID_ENTRIES);
    localparam int SH_L = (WEIGHT_FRAC_BITS < 16) ? 16 - WEIGHT_FRAC_BITS : 0;
    localparam int SH_R = (WEIGHT_FRAC_BITS > 16) ? WEIGHT_FRAC_BITS - 16 : 0;
    localparam int US   = 32 - WEIGHT_FRAC_BITS;

    // Weight reset constants
    localparam logic signed [23:0] RST_HW0 = 24'((64'd372 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_HW1 = 24'((64'd815 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_HW2 = 24'((64'd104 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_HW3 = 24'((64'd593 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_OW0 = 24'((64'd247 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_OW1 = 24'((64'd681 << WEIGHT_FRAC_BITS) / 1000);
    localparam logic signed [23:0] RST_OW2 = 24'((64'd938 << WEIGHT_FRAC_BITS) / 1000);
    localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;

    // Long division by shift and subtract, used only at elaboration
    function automatic longint unsigned udiv64(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned q;
        longint unsigned rem;
        int              b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at the center of bin i, evaluated at elaboration
    function automatic logic [15:0] sig_entry(input int unsigned i);
        longint            zq;
        longint            sum;
        longint            s;
        longint unsigned   t;
        longint unsigned   ip;
        longint unsigned   fr;
        longint unsigned   term;
        longint unsigned   r;
        longint unsigned   d;
        longint unsigned   sp;
        int                k;
        zq = -64'sd524288 + longint'(udiv64((64'(i) * 2 + 1) << 20,
                                            64'(SIGMOID_ENTRIES) * 2));
        t    = longint'(zq < 0 ? -zq : zq);
        ip   = t >> 16;
        fr   = t & 64'hFFFF;
        term = 64'd1 << 32;
        sum  = 64'sd1 << 32;
        // exp(-frac) by its series, twelve terms
        term = udiv64(term * fr, 64'd65536 * 1);  sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 2);  sum = sum + longint'(term);
        term = udiv64(term * fr, 64'd65536 * 3);  sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 4);  sum = sum + longint'(term);
        term = udiv64(term * fr, 64'd65536 * 5);  sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 6);  sum = sum + longint'(term);
        term = udiv64(term * fr, 64'd65536 * 7);  sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 8);  sum = sum + longint'(term);
        term = udiv64(term * fr, 64'd65536 * 9);  sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 10); sum = sum + longint'(term);
        term = udiv64(term * fr, 64'd65536 * 11); sum = sum - longint'(term);
        term = udiv64(term * fr, 64'd65536 * 12); sum = sum + longint'(term);
        r = longint'(sum);
        // times exp(-1) per integer part
        for (k = 0; k < 8; k++) begin
            if (64'(k) < ip) begin
                r = (r * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
            end
        end
        d  = (64'd1 << 32) + r;
        sp = udiv64((64'd1 << 48) + (d >> 1), d);
        s  = (zq >= 0) ? longint'(sp) : 64'sd65536 - longint'(sp);
        if (s < 1) begin
            s = 1;
        end
        if (s > 65535) begin
            s = 65535;
        end
        return 16'(s);
    endfunction

    // Sigmoid table
    logic [15:0] w_tab [SIGMOID_ENTRIES];
    for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_tab
        localparam logic [15:0] TAB_V = sig_entry(gi);
        assign w_tab[gi] = TAB_V;
    end

    // State
    osac_pkg::t_state r_state, n_state;
    logic        r_j, n_j;
    logic        r_cmd, n_cmd;
    logic [15:0] r_x, n_x;
    logic [15:0] r_alpha, r_beta, r_ptgt;
    logic signed [23:0] r_hw0, r_hw1, r_hw2, r_hw3, r_ow0, r_ow1, r_ow2;
    logic signed [23:0] n_hw0, n_hw1, n_hw2, n_hw3, n_ow0, n_ow1, n_ow2;
    logic [15:0] r_a0, n_a0, r_a1, n_a1, r_b0, n_b0, r_h, n_h;
    logic signed [26:0] r_z, n_z;
    logic signed [17:0] r_d3, n_d3;
    logic [22:0] r_q1, n_q1;
    logic signed [23:0] r_kl, n_kl, r_klt, n_klt;
    logic signed [33:0] r_t, n_t, r_d2, n_d2, r_g, n_g;
    logic [14:0] r_sg, n_sg;
    logic signed [53:0] r_prod, n_prod;
    logic        r_white, n_white;
    logic        r_out_valid, n_out_valid;
    logic        r_ow_wh, n_ow_wh;
    logic [15:0] r_o_a0, n_o_a0, r_o_a1, n_o_a1, r_o_rec, n_o_rec;

    // Shared multiplier operands
    logic signed [35:0] m_a;
    logic signed [17:0] m_b;

    osac_pkg::t_div_req w_div_req;
    osac_pkg::t_div_rsp w_div_rsp;

    // Sigmoid lookup on r_z
    logic signed [35:0] w_ze, w_zq, w_off;
    logic [32:0]        w_scaled;
    logic [IW-1:0]      w_idx;
    logic [15:0]        w_sig;

    always_comb begin
        w_ze     = 36'(r_z);
        w_zq     = (w_ze <<< SH_L) >>> SH_R;
        w_off    = w_zq + 36'sd524288;
        w_scaled = 33'(w_off[19:0]) * 33'(SIGMOID_ENTRIES);
        if (w_zq < -36'sd524288) begin
            w_idx = '0;
        end else if (w_zq >= 36'sd524288) begin
            w_idx = IW'(SIGMOID_ENTRIES - 1);
        end else begin
            w_idx = w_scaled[20 +: IW];
        end
    end
    assign w_sig = w_tab[w_idx];

    // Hidden unit under backprop
    logic [15:0]        w_aj;
    logic [16:0]        w_aj_c;
    logic signed [23:0] w_owj;
    logic signed [53:0] w_shw, w_dec;
    logic               w_dom;

    assign w_aj   = r_j ? r_a1 : r_a0;
    assign w_aj_c = 17'd65536 - {1'b0, w_aj};
    assign w_owj  = r_j ? r_ow2 : r_ow1;
    assign w_shw  = r_prod >>> WEIGHT_FRAC_BITS;
    assign w_dec  = r_prod >>> US;
    assign w_dom  = (w_sig >= r_b0);

    osac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_hw0 = r_hw0; n_hw1 = r_hw1; n_hw2 = r_hw2; n_hw3 = r_hw3;
        n_ow0 = r_ow0; n_ow1 = r_ow1; n_ow2 = r_ow2;
        n_a0 = r_a0; n_a1 = r_a1; n_b0 = r_b0; n_h = r_h;
        n_z = r_z; n_d3 = r_d3; n_q1 = r_q1; n_kl = r_kl; n_klt = r_klt;
        n_t = r_t; n_d2 = r_d2; n_g = r_g; n_sg = r_sg;
        n_white     = r_white;
        n_ow_wh     = r_ow_wh;
        n_o_a0      = r_o_a0;
        n_o_a1      = r_o_a1;
        n_o_rec     = r_o_rec;
        n_out_valid = r_out_valid;
        m_a         = '0;
        m_b         = '0;
        w_div_req   = '0;

        // result beat taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            osac_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_sample;
                    n_cmd   = i_cmd;
                    n_state = osac_pkg::S_F0;
                end
            end
            // forward pass, hidden layer
            osac_pkg::S_F0: begin
                m_a = 36'(r_hw2); m_b = $signed({2'b00, r_x});
                n_state = osac_pkg::S_F1;
            end
            osac_pkg::S_F1: begin
                n_z = 27'(r_hw0) + $signed(r_prod[42:16]);
                m_a = 36'(r_hw3); m_b = $signed({2'b00, r_x});
                n_state = osac_pkg::S_F2;
            end
            osac_pkg::S_F2: begin
                n_a0 = w_sig;
                n_z  = 27'(r_hw1) + $signed(r_prod[42:16]);
                n_state = osac_pkg::S_F3;
            end
            osac_pkg::S_F3: begin
                n_a1 = w_sig;
                if (r_cmd) begin
                    n_z = 27'(r_hw0);
                    n_state = osac_pkg::S_C0;
                end else begin
                    m_a = 36'(r_ow1); m_b = $signed({2'b00, r_a0});
                    n_state = osac_pkg::S_T0;
                end
            end
            // classify: dominant unit for a zero sample
            osac_pkg::S_C0: begin
                n_b0 = w_sig;
                n_z  = 27'(r_hw1);
                n_state = osac_pkg::S_C1;
            end
            osac_pkg::S_C1: begin
                if (w_dom) begin
                    n_white = !(r_a1 >= r_a0);
                end else begin
                    n_white = !(r_a0 >= r_a1);
                end
                n_h = '0;
                n_state = osac_pkg::S_OUT;
            end
            // forward pass, output unit
            osac_pkg::S_T0: begin
                n_z = 27'(r_ow0) + $signed(r_prod[42:16]);
                m_a = 36'(r_ow2); m_b = $signed({2'b00, r_a1});
                n_state = osac_pkg::S_T1;
            end
            osac_pkg::S_T1: begin
                n_z = r_z + $signed(r_prod[42:16]);
                n_state = osac_pkg::S_T2;
            end
            osac_pkg::S_T2: begin
                n_h = w_sig;
                n_state = osac_pkg::S_T3;
            end
            osac_pkg::S_T3: begin
                n_d3    = $signed({2'b00, r_h}) - $signed({2'b00, r_x});
                n_j     = 1'b0;
                n_white = 1'b0;
                n_state = osac_pkg::S_B0;
            end
            // KL term: (1-p)/(1-a) - p/a
            osac_pkg::S_B0: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = 17'd65536 - {1'b0, r_ptgt};
                w_div_req.den   = w_aj_c[15:0];
                n_state = osac_pkg::S_B0W;
            end
            osac_pkg::S_B0W: begin
                if (w_div_rsp.done) begin
                    n_q1 = w_div_rsp.quot;
                    n_state = osac_pkg::S_B1;
                end
            end
            osac_pkg::S_B1: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = {1'b0, r_ptgt};
                w_div_req.den   = w_aj;
                n_state = osac_pkg::S_B1W;
            end
            osac_pkg::S_B1W: begin
                if (w_div_rsp.done) begin
                    n_kl = $signed({1'b0, r_q1}) - $signed({1'b0, w_div_rsp.quot});
                    n_state = osac_pkg::S_B2;
                end
            end
            // hidden delta
            osac_pkg::S_B2: begin
                m_a = 36'(r_kl); m_b = $signed({2'b00, r_beta});
                n_state = osac_pkg::S_B3;
            end
            osac_pkg::S_B3: begin
                n_klt = $signed(r_prod[39:16]);
                m_a = 36'(w_owj); m_b = r_d3;
                n_state = osac_pkg::S_B4;
            end
            osac_pkg::S_B4: begin
                n_t = $signed(w_shw[33:0]) + 34'(r_klt);
                m_a = $signed({19'd0, w_aj_c}); m_b = $signed({2'b00, w_aj});
                n_state = osac_pkg::S_B5;
            end
            osac_pkg::S_B5: begin
                n_sg = r_prod[30:16];
                n_state = osac_pkg::S_B6;
            end
            osac_pkg::S_B6: begin
                m_a = 36'(r_t); m_b = $signed({3'b000, r_sg});
                n_state = osac_pkg::S_B7;
            end
            osac_pkg::S_B7: begin
                n_d2 = $signed(r_prod[49:16]);
                n_state = osac_pkg::S_B8;
            end
            // hidden bias weight update
            osac_pkg::S_B8: begin
                m_a = 36'(r_d2); m_b = $signed({2'b00, r_alpha});
                n_state = osac_pkg::S_B9;
            end
            osac_pkg::S_B9: begin
                if (r_j) begin
                    n_hw1 = osac_pkg::sat_sub(r_hw1, w_dec);
                end else begin
                    n_hw0 = osac_pkg::sat_sub(r_hw0, w_dec);
                end
                m_a = 36'(r_d2); m_b = $signed({2'b00, r_x});
                n_state = osac_pkg::S_B10;
            end
            // hidden input weight update
            osac_pkg::S_B10: begin
                n_g = $signed(r_prod[49:16]);
                n_state = osac_pkg::S_B11;
            end
            osac_pkg::S_B11: begin
                m_a = 36'(r_g); m_b = $signed({2'b00, r_alpha});
                n_state = osac_pkg::S_B12;
            end
            osac_pkg::S_B12: begin
                if (r_j) begin
                    n_hw3 = osac_pkg::sat_sub(r_hw3, w_dec);
                    n_state = osac_pkg::S_U0;
                end else begin
                    n_hw2 = osac_pkg::sat_sub(r_hw2, w_dec);
                    n_j = 1'b1;
                    n_state = osac_pkg::S_B0;
                end
            end
            // output weight updates
            osac_pkg::S_U0: begin
                m_a = 36'(r_d3); m_b = $signed({2'b00, r_alpha});
                n_state = osac_pkg::S_U1;
            end
            osac_pkg::S_U1: begin
                n_ow0 = osac_pkg::sat_sub(r_ow0, w_dec);
                m_a = 36'(r_d3); m_b = $signed({2'b00, r_a0});
                n_state = osac_pkg::S_U2;
            end
            osac_pkg::S_U2: begin
                n_g = $signed(r_prod[49:16]);
                n_state = osac_pkg::S_U3;
            end
            osac_pkg::S_U3: begin
                m_a = 36'(r_g); m_b = $signed({2'b00, r_alpha});
                n_state = osac_pkg::S_U4;
            end
            osac_pkg::S_U4: begin
                n_ow1 = osac_pkg::sat_sub(r_ow1, w_dec);
                m_a = 36'(r_d3); m_b = $signed({2'b00, r_a1});
                n_state = osac_pkg::S_U5;
            end
            osac_pkg::S_U5: begin
                n_g = $signed(r_prod[49:16]);
                n_state = osac_pkg::S_U6;
            end
            osac_pkg::S_U6: begin
                m_a = 36'(r_g); m_b = $signed({2'b00, r_alpha});
                n_state = osac_pkg::S_U7;
            end
            osac_pkg::S_U7: begin
                n_ow2 = osac_pkg::sat_sub(r_ow2, w_dec);
                n_state = osac_pkg::S_OUT;
            end
            // load the result beat once the register is free
            osac_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_ow_wh     = r_white;
                    n_o_a0      = r_a0;
                    n_o_a1      = r_a1;
                    n_o_rec     = r_h;
                    n_state     = osac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = osac_pkg::S_IDLE;
            end
        endcase
        n_prod = m_a * m_b;
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= osac_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_alpha     <= osac_pkg::RST_LEARN_RATE;
            r_beta      <= osac_pkg::RST_SPARSITY_WEIGHT;
            r_ptgt      <= osac_pkg::RST_SPARSITY_TARGET;
            r_hw0 <= RST_HW0; r_hw1 <= RST_HW1; r_hw2 <= RST_HW2; r_hw3 <= RST_HW3;
            r_ow0 <= RST_OW0; r_ow1 <= RST_OW1; r_ow2 <= RST_OW2;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hw0 <= n_hw0; r_hw1 <= n_hw1; r_hw2 <= n_hw2; r_hw3 <= n_hw3;
            r_ow0 <= n_ow0; r_ow1 <= n_ow1; r_ow2 <= n_ow2;
            // configuration writes; unknown index ignored
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    osac_pkg::CFG_LEARN_RATE:      r_alpha <= i_cfg_data;
                    osac_pkg::CFG_SPARSITY_WEIGHT: r_beta  <= i_cfg_data;
                    osac_pkg::CFG_SPARSITY_TARGET: r_ptgt  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_j <= n_j; r_cmd <= n_cmd; r_x <= n_x;
        r_a0 <= n_a0; r_a1 <= n_a1; r_b0 <= n_b0; r_h <= n_h;
        r_z <= n_z; r_d3 <= n_d3; r_q1 <= n_q1; r_kl <= n_kl; r_klt <= n_klt;
        r_t <= n_t; r_d2 <= n_d2; r_g <= n_g; r_sg <= n_sg;
        r_prod <= n_prod;
        r_white <= n_white;
        r_ow_wh <= n_ow_wh; r_o_a0 <= n_o_a0; r_o_a1 <= n_o_a1; r_o_rec <= n_o_rec;
    end

    assign o_in_stall          = (r_state != osac_pkg::S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_is_white          = r_ow_wh;
    assign o_hidden_act_first  = r_o_a0;
    assign o_hidden_act_second = r_o_a1;
    assign o_reconstruction    = r_o_rec;

endmodule

// ===== hw/rtl/osac_chk.sv =====
// ----------------------------------------------------------------------------
// osac_chk
// Port-level checks of the classifier core, bound to the top level.
// ----------------------------------------------------------------------------
module osac_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_white,
    input logic [15:0] o_hidden_act_first,
    input logic [15:0] o_hidden_act_second,
    input logic [15:0] o_reconstruction
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_is_white)
            && $stable(o_hidden_act_first) && $stable(o_hidden_act_second)
            && $stable(o_reconstruction)))
        else $error("stalled result beat changed");

    // One item in flight: stall rises right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted while busy");

    // A white answer only comes from a classify beat, which has no reconstruction
    a_white_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_white) |-> (o_reconstruction == 16'd0))
        else $error("white answer carries a reconstruction");

    // Clamped sigmoid never yields zero activations
    a_act_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hidden_act_first != 16'd0 && o_hidden_act_second != 16'd0))
        else $error("zero hidden activation");

    // Reset empties the result register
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind online_sparse_autoencoder_classifier_core osac_chk u_osac_chk (.*);
